[design/dwtd_pkg.sv]
// ----------------------------------------------------------------------------
// dwtd_pkg
// Shared types, register codes and helpers of the dual wheel trigger decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dwtd_pkg;

   // Register file
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOOTH_COUNT            = 3'd0,
      CSR_TWIN_REV               = 3'd1,
      CSR_RESYNC_ENABLE          = 3'd2,
      CSR_STARTUP_CYCLES         = 3'd3,
      CSR_FILTER_MODE            = 3'd4,
      CSR_PRIMARY_FILTER_START   = 3'd5,
      CSR_SECONDARY_FILTER_START = 3'd6
   } csr_index_type;

   // Filter derivation codes
   typedef enum logic [1:0] {
      FILTER_OFF           = 2'd0,
      FILTER_QUARTER       = 2'd1,
      FILTER_HALF          = 2'd2,
      FILTER_THREE_QUARTER = 2'd3
   } filter_mode_type;

   // Reset values
   localparam logic [7:0]  TOOTH_COUNT_RESET    = 8'd36;
   localparam logic [7:0]  TOOTH_COUNTER_RESET  = 8'd255;
   localparam logic [31:0] SYNC_LOSS_MIN_REVS   = 32'd2;

   typedef enum logic {
      EDGE_PRIMARY   = 1'b0,
      EDGE_SECONDARY = 1'b1
   } edge_source_type;

   // Input item
   typedef struct packed {
      logic        op;
      logic [31:0] timestamp;
      logic [31:0] revolution_time;
   } req_type;

   // Result item
   typedef struct packed {
      logic        accepted;
      logic [7:0]  tooth_number;
      logic        revolution_start;
      logic        in_sync;
      logic        second_revolution;
      logic [31:0] revolutions;
      logic [7:0]  sync_losses;
      logic [31:0] edge_gap;
   } rsp_type;

   // Static configuration seen by the decoder core
   typedef struct packed {
      logic [7:0]      tooth_count;
      logic            twin_rev;
      logic            resync_enable;
      logic [7:0]      startup_cycles;
      filter_mode_type filter_mode;
   } cfg_type;

   // Filter preload requests raised by register writes
   typedef struct packed {
      logic        primary_load;
      logic [31:0] primary_value;
      logic        secondary_load;
      logic [31:0] secondary_value;
   } load_type;

   // Primary filter derived from the last accepted tooth gap
   function automatic logic [31:0] filter_from_gap(input filter_mode_type mode,
                                                   input logic [31:0]     gap);
      logic [31:0] result;
      result = '0;
      unique case (mode)
         FILTER_OFF:           result = '0;
         FILTER_QUARTER:       result = gap >> 2;
         FILTER_HALF:          result = gap >> 1;
         FILTER_THREE_QUARTER: result = (gap >> 1) + (gap >> 2);
         default:              result = '0;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

[design/dwtd_csr.sv]
// ----------------------------------------------------------------------------
// dwtd_csr
// Configuration registers; raises filter preload requests on writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtd_csr
   import dwtd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_data,
   output cfg_type                         cfg,
   output load_type                        load
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   // Always able to take a write
   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      load   = '{primary_load: 1'b0, primary_value: csr_data,
                 secondary_load: 1'b0, secondary_value: csr_data};
      if (write) begin
         unique case (csr_index)
            CSR_TOOTH_COUNT:            cfg_in.tooth_count    = csr_data[7:0];
            CSR_TWIN_REV:               cfg_in.twin_rev       = csr_data[0];
            CSR_RESYNC_ENABLE:          cfg_in.resync_enable  = csr_data[0];
            CSR_STARTUP_CYCLES:         cfg_in.startup_cycles = csr_data[7:0];
            CSR_FILTER_MODE:            cfg_in.filter_mode    = filter_mode_type'(csr_data[1:0]);
            CSR_PRIMARY_FILTER_START:   load.primary_load     = 1'b1;
            CSR_SECONDARY_FILTER_START: load.secondary_load   = 1'b1;
            default: ;
         endcase
      end
   end

   // Hold the settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tooth_count: TOOTH_COUNT_RESET, twin_rev: 1'b0,
                     resync_enable: 1'b0, startup_cycles: 8'd0,
                     filter_mode: FILTER_QUARTER};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/dwtd_core.sv]
// ----------------------------------------------------------------------------
// dwtd_core
// Decoder state and the single-pass update for one edge.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtd_core
   import dwtd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  req_type   item,
   input  cfg_type   cfg,
   input  load_type  load,
   output rsp_type   result
);

   logic [7:0]  tooth_ff, tooth_in;
   logic [31:0] last_pri_ff, last_pri_in;
   logic [31:0] last_sec_ff, last_sec_in;
   logic [31:0] pri_filter_ff, pri_filter_in;
   logic [31:0] sec_filter_ff, sec_filter_in;
   logic        sync_ff, sync_in;
   logic        phase_ff, phase_in;
   logic [31:0] revs_ff, revs_in;
   logic [7:0]  losses_ff, losses_in;

   logic [31:0] gap;
   logic        pass;
   logic        rev_start;
   logic [7:0]  tooth_next;

   // Work out the edge update
   always_comb begin
      tooth_in      = tooth_ff;
      last_pri_in   = last_pri_ff;
      last_sec_in   = last_sec_ff;
      pri_filter_in = pri_filter_ff;
      sec_filter_in = sec_filter_ff;
      sync_in       = sync_ff;
      phase_in      = phase_ff;
      revs_in       = revs_ff;
      losses_in     = losses_ff;
      rev_start     = 1'b0;
      tooth_next    = tooth_ff + 8'd1;

      if (item.op == EDGE_PRIMARY) begin
         gap  = item.timestamp - last_pri_ff;
         pass = (gap >= pri_filter_ff);
      end else begin
         gap  = item.timestamp - last_sec_ff;
         pass = (gap >= sec_filter_ff);
      end

      if (item.op == EDGE_PRIMARY) begin
         // Advance the tooth, wrap at the tooth count once in sync
         if (pass) begin
            tooth_in    = tooth_next;
            last_pri_in = item.timestamp;
            if (sync_ff) begin
               if (tooth_next == 8'd1 || tooth_next > cfg.tooth_count) begin
                  tooth_in  = 8'd1;
                  phase_in  = ~phase_ff;
                  revs_in   = revs_ff + (cfg.twin_rev ? 32'd2 : 32'd1);
                  rev_start = 1'b1;
               end
               pri_filter_in = filter_from_gap(cfg.filter_mode, gap);
            end
         end
      end else begin
         // Acquire or check sync on the secondary edge
         if (pass) begin
            last_sec_in   = item.timestamp;
            sec_filter_in = gap >> 2;
            if (!sync_ff || revs_ff <= {24'd0, cfg.startup_cycles}) begin
               last_pri_in   = item.timestamp;
               tooth_in      = cfg.tooth_count;
               pri_filter_in = '0;
               sync_in       = 1'b1;
            end else begin
               if (tooth_ff != cfg.tooth_count && revs_ff > SYNC_LOSS_MIN_REVS) begin
                  losses_in = losses_ff + 8'd1;
               end
               if (cfg.resync_enable) begin
                  tooth_in = cfg.tooth_count;
               end
            end
            phase_in = 1'b1;
         end else begin
            sec_filter_in = item.revolution_time >> 1;
         end
      end
   end

   // Result reflects the state after this edge
   assign result = '{accepted: pass, tooth_number: tooth_in,
                     revolution_start: rev_start, in_sync: sync_in,
                     second_revolution: phase_in, revolutions: revs_in,
                     sync_losses: losses_in, edge_gap: gap};

   // Commit the update; register writes preload the filters
   always_ff @(posedge clock) begin
      if (reset) begin
         tooth_ff      <= TOOTH_COUNTER_RESET;
         last_pri_ff   <= '0;
         last_sec_ff   <= '0;
         pri_filter_ff <= '0;
         sec_filter_ff <= '0;
         sync_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         revs_ff       <= '0;
         losses_ff     <= '0;
      end else begin
         if (step) begin
            tooth_ff      <= tooth_in;
            last_pri_ff   <= last_pri_in;
            last_sec_ff   <= last_sec_in;
            pri_filter_ff <= pri_filter_in;
            sec_filter_ff <= sec_filter_in;
            sync_ff       <= sync_in;
            phase_ff      <= phase_in;
            revs_ff       <= revs_in;
            losses_ff     <= losses_in;
         end
         if (load.primary_load) begin
            pri_filter_ff <= load.primary_value;
         end
         if (load.secondary_load) begin
            sec_filter_ff <= load.secondary_value;
         end
      end
   end

endmodule

`default_nettype wire

[design/dual_wheel_trigger_decoder.sv]
// ----------------------------------------------------------------------------
// dual_wheel_trigger_decoder
// Crank/cam trigger decoder: noise filters, tooth counting and sync tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one edge per transfer (source, timestamp, revolution period).
//            A transfer completes on a clock edge with req_valid high and
//            req_stall low.
//   rsp_*  : one result per edge, in order, taken when rsp_valid is high and
//            rsp_stall is low.
//   csr_*  : register writes, index and data; csr_ready is always high.
//            Write only while no edge is in flight.
//   The edge passes through the input register, then the result register,
//   before rsp_valid rises. Throughput: one edge per cycle while rsp is not
//   stalled, set by the single update pass on the decoder state registers.
//   Reset (synchronous) empties both registers and returns the settings and
//   the decoder state to their initial values.
//   A stall on rsp holds the result; the input register still fills, and
//   req_stall rises only once both registers hold an edge.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_trigger_decoder
   import dwtd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  req_type                         req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;
   logic     advance;
   logic     req_take;
   cfg_type  cfg;
   load_type load;
   rsp_type  result;

   dwtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .load      (load)
   );

   dwtd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .load   (load),
      .result (result)
   );

   // Move the held edge on when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[design/dwtd_checker.sv]
// ----------------------------------------------------------------------------
// dwtd_checker
// Port-level checks of the trigger decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtd_checker
   import dwtd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input rsp_type   rsp_data
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Leave reset empty and ready
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // A revolution start is an accepted tooth one with sync
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.revolution_start |->
         rsp_data.accepted && rsp_data.in_sync && rsp_data.tooth_number == 8'd1)
      else $error("revolution start without sync at tooth one");

   // Sync, once shown, is never dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.in_sync |=> !rsp_valid || rsp_data.in_sync)
      else $error("sync flag fell");

endmodule

bind dual_wheel_trigger_decoder dwtd_checker u_dwtd_checker (.*);

`default_nettype wire
